### design/rid_pkg.sv
`timescale 1ns / 1ps

package rid_pkg;

    // Major opcodes of the supported subset.
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FLOAD  = 7'h07;
    localparam logic [6:0] OPC_FSTORE = 7'h27;
    localparam logic [6:0] OPC_FOP    = 7'h53;
    localparam logic [6:0] OPC_ROT    = 7'h0B;
    localparam logic [6:0] OPC_IO     = 7'h01;

    // funct7 codes.
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_FADD   = 7'h00;
    localparam logic [6:0] F7_FSUB   = 7'h04;
    localparam logic [6:0] F7_FMUL   = 7'h08;
    localparam logic [6:0] F7_FDIV   = 7'h0C;
    localparam logic [6:0] F7_FCMP   = 7'h50;
    localparam logic [6:0] F7_FMVSX  = 7'h78;
    localparam logic [6:0] F7_FMVXS  = 7'h70;
    localparam logic [6:0] F7_FCVTSW = 7'h68;
    localparam logic [6:0] F7_FCVTWS = 7'h60;
    localparam logic [6:0] F7_FSQRT  = 7'h2C;
    localparam logic [6:0] F7_FSGNJ  = 7'h10;

    // Bits kept of the immediate of an arithmetic right shift.
    localparam logic [31:0] SRAI_MASK = 32'h0000_041F;

    typedef enum logic [5:0] {
        OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
        OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
        OP_SB, OP_SH, OP_SW,
        OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
        OP_SLLI, OP_SRLI, OP_SRAI,
        OP_ADD, OP_SUB, OP_MUL, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_DIV,
        OP_SRL, OP_SRA, OP_OR, OP_AND,
        OP_FLW, OP_FSW,
        OP_FADDS, OP_FSUBS, OP_FMULS, OP_FDIVS, OP_FEQS, OP_FLTS, OP_FLES,
        OP_FMVSX, OP_FMVXS, OP_FCVTSW, OP_FCVTWS, OP_FSQRTS, OP_FSGNJXS,
        OP_ROT, OP_IN, OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_UNKNOWN = 2'd1,
        ERR_RM      = 2'd2
    } err_t;

    typedef struct packed {
        op_t         op;
        logic [4:0]  one;
        logic [31:0] two;
        logic [31:0] three;
        err_t        err;
    } result_t;

endpackage

### design/rid_decode.sv
`timescale 1ns / 1ps

module rid_decode
    import rid_pkg::*;
(
    input  logic [31:0] word,
    output result_t     res
);

    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    op_t         op;
    err_t        err;
    logic [4:0]  a;
    logic [31:0] b;
    logic [31:0] c;

    assign opc = word[6:0];
    assign f7  = word[31:25];
    assign f3  = word[14:12];
    assign rd  = word[11:7];
    assign rs1 = word[19:15];
    assign rs2 = word[24:20];

    assign imm_i = {{20{word[31]}}, word[31:20]};
    assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

    always_comb
    begin
        op  = OP_LUI;
        err = ERR_UNKNOWN;
        a   = 5'd0;
        b   = 32'd0;
        c   = 32'd0;
        unique case (opc)
            OPC_LUI, OPC_AUIPC:
            begin
                op  = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
                err = ERR_NONE;
                a   = rd;
                b   = {word[31:12], 12'd0};
            end
            OPC_JAL:
            begin
                op  = OP_JAL;
                err = ERR_NONE;
                a   = rd;
                b   = imm_j;
            end
            OPC_JALR:
            begin
                op  = OP_JALR;
                err = ERR_NONE;
                a   = rd;
                b   = {27'd0, rs1};
                c   = imm_i;
            end
            OPC_BRANCH:
            begin
                a   = rs1;
                b   = {27'd0, rs2};
                c   = imm_b;
                err = ERR_NONE;
                unique case (f3)
                    3'd0:    op = OP_BEQ;
                    3'd1:    op = OP_BNE;
                    3'd4:    op = OP_BLT;
                    3'd5:    op = OP_BGE;
                    3'd6:    op = OP_BLTU;
                    3'd7:    op = OP_BGEU;
                    default: err = ERR_UNKNOWN;
                endcase
            end
            OPC_LOAD:
            begin
                a   = rd;
                b   = {27'd0, rs1};
                c   = imm_i;
                err = ERR_NONE;
                unique case (f3)
                    3'd0:    op = OP_LB;
                    3'd1:    op = OP_LH;
                    3'd2:    op = OP_LW;
                    3'd4:    op = OP_LBU;
                    3'd5:    op = OP_LHU;
                    default: err = ERR_UNKNOWN;
                endcase
            end
            OPC_STORE:
            begin
                a   = rs1;
                b   = {27'd0, rs2};
                c   = imm_s;
                err = ERR_NONE;
                unique case (f3)
                    3'd0:    op = OP_SB;
                    3'd1:    op = OP_SH;
                    3'd2:    op = OP_SW;
                    default: err = ERR_UNKNOWN;
                endcase
            end
            OPC_OPIMM:
            begin
                a   = rd;
                b   = {27'd0, rs1};
                c   = imm_i;
                err = ERR_NONE;
                unique case (f3)
                    3'd0: op = OP_ADDI;
                    3'd2: op = OP_SLTI;
                    3'd3: op = OP_SLTIU;
                    3'd4: op = OP_XORI;
                    3'd6: op = OP_ORI;
                    3'd7: op = OP_ANDI;
                    3'd1:
                    begin
                        op = OP_SLLI;
                        if (f7 != F7_BASE)
                            err = ERR_UNKNOWN;
                    end
                    default:
                    begin
                        if (f7 == F7_BASE)
                            op = OP_SRLI;
                        else if (f7 == F7_ALT)
                        begin
                            op = OP_SRAI;
                            c  = imm_i & SRAI_MASK;
                        end
                        else
                            err = ERR_UNKNOWN;
                    end
                endcase
            end
            OPC_OP:
            begin
                a   = rd;
                b   = {27'd0, rs1};
                c   = {27'd0, rs2};
                err = ERR_UNKNOWN;
                unique case (f3)
                    3'd0:
                    begin
                        if (f7 == F7_BASE)        begin op = OP_ADD; err = ERR_NONE; end
                        else if (f7 == F7_ALT)    begin op = OP_SUB; err = ERR_NONE; end
                        else if (f7 == F7_MULDIV) begin op = OP_MUL; err = ERR_NONE; end
                    end
                    3'd1: if (f7 == F7_BASE) begin op = OP_SLL;  err = ERR_NONE; end
                    3'd2: if (f7 == F7_BASE) begin op = OP_SLT;  err = ERR_NONE; end
                    3'd3: if (f7 == F7_BASE) begin op = OP_SLTU; err = ERR_NONE; end
                    3'd4:
                    begin
                        if (f7 == F7_BASE)        begin op = OP_XOR; err = ERR_NONE; end
                        else if (f7 == F7_MULDIV) begin op = OP_DIV; err = ERR_NONE; end
                    end
                    3'd5:
                    begin
                        if (f7 == F7_BASE)     begin op = OP_SRL; err = ERR_NONE; end
                        else if (f7 == F7_ALT) begin op = OP_SRA; err = ERR_NONE; end
                    end
                    3'd6: if (f7 == F7_BASE) begin op = OP_OR;  err = ERR_NONE; end
                    default: if (f7 == F7_BASE) begin op = OP_AND; err = ERR_NONE; end
                endcase
            end
            OPC_FLOAD:
            begin
                op  = OP_FLW;
                a   = rd;
                b   = {27'd0, rs1};
                c   = imm_i;
                err = (f3 == 3'd2) ? ERR_NONE : ERR_UNKNOWN;
            end
            OPC_FSTORE:
            begin
                op  = OP_FSW;
                a   = rs1;
                b   = {27'd0, rs2};
                c   = imm_s;
                err = (f3 == 3'd2) ? ERR_NONE : ERR_UNKNOWN;
            end
            OPC_FOP:
            begin
                a   = rd;
                b   = {27'd0, rs1};
                c   = {27'd0, rs2};
                err = ERR_UNKNOWN;
                // The rounding mode is checked ahead of the unused rs2 field.
                unique case (f7)
                    F7_FADD:   begin op = OP_FADDS; err = (f3 != 3'd0) ? ERR_RM : ERR_NONE; end
                    F7_FSUB:   begin op = OP_FSUBS; err = (f3 != 3'd0) ? ERR_RM : ERR_NONE; end
                    F7_FMUL:   begin op = OP_FMULS; err = (f3 != 3'd0) ? ERR_RM : ERR_NONE; end
                    F7_FDIV:   begin op = OP_FDIVS; err = (f3 != 3'd0) ? ERR_RM : ERR_NONE; end
                    F7_FCMP:
                    begin
                        err = ERR_NONE;
                        if (f3 == 3'd2)      op = OP_FEQS;
                        else if (f3 == 3'd1) op = OP_FLTS;
                        else if (f3 == 3'd0) op = OP_FLES;
                        else                 err = ERR_UNKNOWN;
                    end
                    F7_FMVSX:
                    begin
                        op = OP_FMVSX;
                        if (f3 == 3'd0 && rs2 == 5'd0) err = ERR_NONE;
                    end
                    F7_FMVXS:
                    begin
                        op = OP_FMVXS;
                        if (f3 == 3'd0 && rs2 == 5'd0) err = ERR_NONE;
                    end
                    F7_FCVTSW:
                    begin
                        op  = OP_FCVTSW;
                        err = (f3 != 3'd0) ? ERR_RM : ((rs2 == 5'd0) ? ERR_NONE : ERR_UNKNOWN);
                    end
                    F7_FCVTWS:
                    begin
                        op  = OP_FCVTWS;
                        err = (f3 != 3'd0) ? ERR_RM : ((rs2 == 5'd0) ? ERR_NONE : ERR_UNKNOWN);
                    end
                    F7_FSQRT:
                    begin
                        op  = OP_FSQRTS;
                        err = (f3 != 3'd0) ? ERR_RM : ((rs2 == 5'd0) ? ERR_NONE : ERR_UNKNOWN);
                    end
                    F7_FSGNJ:
                    begin
                        op = OP_FSGNJXS;
                        if (f3 == 3'd2) err = ERR_NONE;
                    end
                    default: err = ERR_UNKNOWN;
                endcase
            end
            OPC_ROT:
            begin
                op  = OP_ROT;
                a   = rd;
                b   = {27'd0, rs1};
                err = (f3 == 3'd1 && rs2 == 5'd0) ? ERR_NONE : ERR_UNKNOWN;
            end
            OPC_IO:
            begin
                // Both forms carry a zero operand field and a zero immediate, so the
                // only slot left is the register that is read or written.
                if (f3 == 3'd0)
                begin
                    op  = OP_IN;
                    a   = rd;
                    err = (rs1 == 5'd0 && imm_i == 32'd0) ? ERR_NONE : ERR_UNKNOWN;
                end
                else if (f3 == 3'd1)
                begin
                    op  = OP_OUT;
                    a   = rs1;
                    err = (rs2 == 5'd0 && imm_s == 32'd0) ? ERR_NONE : ERR_UNKNOWN;
                end
            end
            default: err = ERR_UNKNOWN;
        endcase
    end

    // A rejected word shows no operation and empty slots.
    always_comb
    begin
        res.err = err;
        if (err == ERR_NONE)
        begin
            res.op    = op;
            res.one   = a;
            res.two   = b;
            res.three = c;
        end
        else
        begin
            res.op    = OP_LUI;
            res.one   = 5'd0;
            res.two   = 32'd0;
            res.three = 32'd0;
        end
    end

endmodule

### design/riscv_instruction_decoder.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    instr_word
// output    out_valid / out_ready  op_code, slot_one, slot_two, slot_three, error_code
//
// An accepted item is captured in the input register and then decoded into the result
// register once that register is empty or its result is taken; out_valid rises when
// the result register is loaded. One item is accepted every cycle while the output
// side takes results. A stalled result holds the result register and the word waiting
// behind it; in_ready stays high while the input register is empty or its word moves
// on. After reset both stages are empty and in_ready is high.

module riscv_instruction_decoder
    import rid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instr_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  op_code,
    output logic [4:0]  slot_one,
    output logic [31:0] slot_two,
    output logic [31:0] slot_three,
    output logic [1:0]  error_code
);

    logic        word_valid_reg;
    logic        word_valid_next;
    logic [31:0] word_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    result_t     res_reg;
    result_t     res_dec;
    logic        res_load;

    rid_decode u_decode
    (
        .word (word_reg),
        .res  (res_dec)
    );

    assign res_load        = word_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready        = !word_valid_reg || res_load;
    assign word_valid_next = (in_valid && in_ready) ? 1'b1 :
                             (res_load ? 1'b0 : word_valid_reg);
    assign res_valid_next  = res_load ? 1'b1 :
                             ((out_ready) ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            word_valid_reg <= word_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            word_reg <= instr_word;
        if (res_load)
            res_reg <= res_dec;
    end

    assign out_valid  = res_valid_reg;
    assign op_code    = res_reg.op;
    assign slot_one   = res_reg.one;
    assign slot_two   = res_reg.two;
    assign slot_three = res_reg.three;
    assign error_code = res_reg.err;

endmodule

### design/rid_checker.sv
`timescale 1ns / 1ps

module rid_checker
    import rid_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [31:0] instr_word,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  op_code,
    input logic [4:0]  slot_one,
    input logic [31:0] slot_two,
    input logic [31:0] slot_three,
    input logic [1:0]  error_code
);

    // A result that is not taken stays on the port unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(op_code) && $stable(slot_one)
            && $stable(slot_two) && $stable(slot_three) && $stable(error_code))
        else $error("result changed while stalled");

    // A rejected word carries no operation and empty slots.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> op_code == 6'd0 && slot_one == 5'd0
            && slot_two == 32'd0 && slot_three == 32'd0)
        else $error("rejected word with nonzero fields");

    // Port instructions use only the first slot.
    a_io_slots: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_NONE
            && (op_code == OP_IN || op_code == OP_OUT)
            |-> slot_two == 32'd0 && slot_three == 32'd0)
        else $error("port instruction with operand slots set");

    // Upper-immediate forms and JAL leave the third slot empty.
    a_u_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_NONE
            && (op_code == OP_LUI || op_code == OP_AUIPC || op_code == OP_JAL)
            |-> slot_three == 32'd0)
        else $error("upper or jump form with third slot set");

endmodule

bind riscv_instruction_decoder rid_checker u_rid_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import rid_pkg::*;

    localparam int RANDOM_ITEMS   = 600;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 8;

    // funct3 values, grouped by the instructions that use them.
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_B    = 3'd0;
    localparam logic [2:0] F3_H    = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_BU   = 3'd4;
    localparam logic [2:0] F3_HU   = 3'd5;
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_FLE  = 3'd0;
    localparam logic [2:0] F3_FLT  = 3'd1;
    localparam logic [2:0] F3_FEQ  = 3'd2;
    localparam logic [2:0] F3_FMV  = 3'd0;
    localparam logic [2:0] F3_FSGNJX = 3'd2;
    localparam logic [2:0] F3_ROT  = 3'd1;
    localparam logic [2:0] F3_IN   = 3'd0;
    localparam logic [2:0] F3_OUT  = 3'd1;
    localparam logic [2:0] F3_RSVD = 3'd3;
    localparam logic [2:0] RM_RNE  = 3'd0;
    localparam logic [2:0] RM_RTZ  = 3'd1;
    localparam logic [2:0] RM_DYN  = 3'd7;

    typedef struct packed {
        logic [31:0] word;
        result_t     res;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] instr_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  op_code;
    logic [4:0]  slot_one;
    logic [31:0] slot_two;
    logic [31:0] slot_three;
    logic [1:0]  error_code;

    logic [31:0] pending_q[$];
    decoded_t    decoded_q[$];
    int          issued = 0;
    int          checked = 0;
    int          mismatches = 0;
    int          ok_cnt = 0;
    int          unknown_cnt = 0;
    int          rm_cnt = 0;
    logic [63:0] op_seen = '0;
    int          in_gap = 0;
    int          out_stall = 0;
    int          idle_cycles = 0;

    riscv_instruction_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .instr_word (instr_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .op_code    (op_code),
        .slot_one   (slot_one),
        .slot_two   (slot_two),
        .slot_three (slot_three),
        .error_code (error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic result_t decode_instr(logic [31:0] w);
        result_t     r;
        op_t         op;
        logic        ok;
        logic        bad_rm;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        rd = w[11:7];
        rs1 = w[19:15];
        rs2 = w[24:20];
        f3 = w[14:12];
        f7 = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r = '0;
        op = OP_LUI;
        ok = 1'b1;
        bad_rm = 1'b0;

        // Operand layout first, operation second; an undecodable word clears it all.
        case (w[6:0])
            OPC_LUI, OPC_AUIPC:
            begin
                op = (w[6:0] == OPC_LUI) ? OP_LUI : OP_AUIPC;
                r.one = rd;
                r.two = {w[31:12], 12'b0};
            end
            OPC_JAL:
            begin
                op = OP_JAL;
                r.one = rd;
                r.two = imm_j;
            end
            OPC_JALR:
            begin
                op = OP_JALR;
                r.one = rd;
                r.two = {27'd0, rs1};
                r.three = imm_i;
            end
            OPC_BRANCH:
            begin
                r.one = rs1;
                r.two = {27'd0, rs2};
                r.three = imm_b;
                case (f3)
                    F3_BEQ:  op = OP_BEQ;
                    F3_BNE:  op = OP_BNE;
                    F3_BLT:  op = OP_BLT;
                    F3_BGE:  op = OP_BGE;
                    F3_BLTU: op = OP_BLTU;
                    F3_BGEU: op = OP_BGEU;
                    default: ok = 1'b0;
                endcase
            end
            OPC_LOAD:
            begin
                r.one = rd;
                r.two = {27'd0, rs1};
                r.three = imm_i;
                case (f3)
                    F3_B:    op = OP_LB;
                    F3_H:    op = OP_LH;
                    F3_W:    op = OP_LW;
                    F3_BU:   op = OP_LBU;
                    F3_HU:   op = OP_LHU;
                    default: ok = 1'b0;
                endcase
            end
            OPC_STORE:
            begin
                r.one = rs1;
                r.two = {27'd0, rs2};
                r.three = imm_s;
                case (f3)
                    F3_B:    op = OP_SB;
                    F3_H:    op = OP_SH;
                    F3_W:    op = OP_SW;
                    default: ok = 1'b0;
                endcase
            end
            OPC_OPIMM:
            begin
                r.one = rd;
                r.two = {27'd0, rs1};
                r.three = imm_i;
                case (f3)
                    F3_ADD:  op = OP_ADDI;
                    F3_SLT:  op = OP_SLTI;
                    F3_SLTU: op = OP_SLTIU;
                    F3_XOR:  op = OP_XORI;
                    F3_OR:   op = OP_ORI;
                    F3_AND:  op = OP_ANDI;
                    F3_SLL:
                    begin
                        op = OP_SLLI;
                        ok = (f7 == F7_BASE);
                    end
                    default:
                    begin
                        if (f7 == F7_BASE)
                        begin
                            op = OP_SRLI;
                        end
                        else if (f7 == F7_ALT)
                        begin
                            op = OP_SRAI;
                            r.three = imm_i & SRAI_MASK;
                        end
                        else
                        begin
                            ok = 1'b0;
                        end
                    end
                endcase
            end
            OPC_OP:
            begin
                r.one = rd;
                r.two = {27'd0, rs1};
                r.three = {27'd0, rs2};
                ok = 1'b0;
                case (f3)
                    F3_ADD:
                    begin
                        if (f7 == F7_BASE) begin op = OP_ADD; ok = 1'b1; end
                        if (f7 == F7_ALT) begin op = OP_SUB; ok = 1'b1; end
                        if (f7 == F7_MULDIV) begin op = OP_MUL; ok = 1'b1; end
                    end
                    F3_XOR:
                    begin
                        if (f7 == F7_BASE) begin op = OP_XOR; ok = 1'b1; end
                        if (f7 == F7_MULDIV) begin op = OP_DIV; ok = 1'b1; end
                    end
                    F3_SR:
                    begin
                        if (f7 == F7_BASE) begin op = OP_SRL; ok = 1'b1; end
                        if (f7 == F7_ALT) begin op = OP_SRA; ok = 1'b1; end
                    end
                    default:
                    begin
                        ok = (f7 == F7_BASE);
                        case (f3)
                            F3_SLL:  op = OP_SLL;
                            F3_SLT:  op = OP_SLT;
                            F3_SLTU: op = OP_SLTU;
                            F3_OR:   op = OP_OR;
                            default: op = OP_AND;
                        endcase
                    end
                endcase
            end
            OPC_FLOAD:
            begin
                op = OP_FLW;
                ok = (f3 == F3_W);
                r.one = rd;
                r.two = {27'd0, rs1};
                r.three = imm_i;
            end
            OPC_FSTORE:
            begin
                op = OP_FSW;
                ok = (f3 == F3_W);
                r.one = rs1;
                r.two = {27'd0, rs2};
                r.three = imm_s;
            end
            OPC_FOP:
            begin
                r.one = rd;
                r.two = {27'd0, rs1};
                r.three = {27'd0, rs2};
                case (f7)
                    F7_FADD, F7_FSUB, F7_FMUL, F7_FDIV:
                    begin
                        bad_rm = (f3 != RM_RNE);
                        case (f7)
                            F7_FADD: op = OP_FADDS;
                            F7_FSUB: op = OP_FSUBS;
                            F7_FMUL: op = OP_FMULS;
                            default: op = OP_FDIVS;
                        endcase
                    end
                    F7_FCVTSW, F7_FCVTWS, F7_FSQRT:
                    begin
                        // The rounding mode is judged before the rs2 field.
                        bad_rm = (f3 != RM_RNE);
                        ok = (rs2 == 5'd0);
                        case (f7)
                            F7_FCVTSW: op = OP_FCVTSW;
                            F7_FCVTWS: op = OP_FCVTWS;
                            default:   op = OP_FSQRTS;
                        endcase
                    end
                    F7_FCMP:
                    begin
                        case (f3)
                            F3_FEQ:  op = OP_FEQS;
                            F3_FLT:  op = OP_FLTS;
                            F3_FLE:  op = OP_FLES;
                            default: ok = 1'b0;
                        endcase
                    end
                    F7_FMVSX, F7_FMVXS:
                    begin
                        op = (f7 == F7_FMVSX) ? OP_FMVSX : OP_FMVXS;
                        ok = (f3 == F3_FMV) && (rs2 == 5'd0);
                    end
                    F7_FSGNJ:
                    begin
                        op = OP_FSGNJXS;
                        ok = (f3 == F3_FSGNJX);
                    end
                    default: ok = 1'b0;
                endcase
            end
            OPC_ROT:
            begin
                op = OP_ROT;
                ok = (f3 == F3_ROT) && (rs2 == 5'd0);
                r.one = rd;
                r.two = {27'd0, rs1};
            end
            OPC_IO:
            begin
                if (f3 == F3_IN)
                begin
                    op = OP_IN;
                    ok = (rs1 == 5'd0) && (imm_i == '0);
                    r.one = rd;
                end
                else if (f3 == F3_OUT)
                begin
                    op = OP_OUT;
                    ok = (rs2 == 5'd0) && (imm_s == '0);
                    r.one = rs1;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            default: ok = 1'b0;
        endcase

        if (bad_rm || !ok)
        begin
            r = '0;
            r.err = bad_rm ? ERR_RM : ERR_UNKNOWN;
        end
        else
        begin
            r.op = op;
            r.err = ERR_NONE;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] word, logic [31:0] want,
                               logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch for word %h: expected %h, actual %h",
                     $time, name, word, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : drive_instr
        logic hold;
        if (rst_n)
        begin
            hold = in_valid;
            if (in_valid && in_ready)
            begin
                decoded_q.push_back('{instr_word, decode_instr(instr_word)});
                issued++;
                in_gap = (((issued / 100) % 4) == 3) ? 0 : $urandom_range(0, 4);
                hold = 1'b0;
            end
            if (!hold)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    instr_word <= pending_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        decoded_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: result with no item outstanding: op %0d err %0d",
                             $time, op_code, error_code);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("op_code", want.word, 32'(want.res.op), 32'(op_code));
                    check_field("slot_one", want.word, 32'(want.res.one), 32'(slot_one));
                    check_field("slot_two", want.word, want.res.two, slot_two);
                    check_field("slot_three", want.word, want.res.three, slot_three);
                    check_field("error_code", want.word, 32'(want.res.err),
                                32'(error_code));
                    checked++;
                    case (want.res.err)
                        ERR_NONE:
                        begin
                            ok_cnt++;
                            op_seen[want.res.op] = 1'b1;
                        end
                        ERR_UNKNOWN: unknown_cnt++;
                        default:     rm_cnt++;
                    endcase
                end
                out_stall = (((checked / 100) % 4) == 3) ? 0 : $urandom_range(0, 4);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                             $time, idle_cycles, decoded_q.size());
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [31:0] w;

        // Field extremes and the corner cases of each format.
        pending_q.push_back(32'h0000_0000);
        pending_q.push_back(32'hFFFF_FFFF);
        pending_q.push_back({20'hFFFFF, 5'd31, OPC_LUI});
        pending_q.push_back({20'h00001, 5'd0, OPC_AUIPC});
        pending_q.push_back({20'hFFFFF, 5'd1, OPC_JAL});
        pending_q.push_back({20'h7FFFF, 5'd31, OPC_JAL});
        pending_q.push_back({12'h800, 5'd31, F3_ADD, 5'd31, OPC_JALR});
        pending_q.push_back(enc_r(7'h7F, 5'd31, 5'd31, F3_BEQ, 5'd31, OPC_BRANCH));
        pending_q.push_back(enc_r(7'h3F, 5'd1, 5'd2, F3_BGEU, 5'd30, OPC_BRANCH));
        pending_q.push_back(enc_r(7'h00, 5'd1, 5'd2, F3_RSVD, 5'd3, OPC_BRANCH));
        pending_q.push_back(enc_r(7'h12, 5'd4, 5'd5, F3_RSVD, 5'd6, OPC_LOAD));
        pending_q.push_back(enc_r(7'h40, 5'd7, 5'd31, F3_W, 5'd0, OPC_STORE));
        pending_q.push_back(enc_r(7'h40, 5'd0, 5'd3, F3_ADD, 5'd4, OPC_OPIMM));
        pending_q.push_back(enc_r(7'h3F, 5'd31, 5'd3, F3_ADD, 5'd4, OPC_OPIMM));
        pending_q.push_back(enc_r(F7_ALT, 5'd31, 5'd9, F3_SR, 5'd10, OPC_OPIMM));
        pending_q.push_back(enc_r(7'h21, 5'd3, 5'd9, F3_SR, 5'd10, OPC_OPIMM));
        pending_q.push_back(enc_r(F7_ALT, 5'd3, 5'd9, F3_SLL, 5'd10, OPC_OPIMM));
        pending_q.push_back(enc_r(F7_BASE, 5'd2, 5'd3, F3_SR, 5'd4, OPC_OP));
        pending_q.push_back(enc_r(F7_ALT, 5'd2, 5'd3, F3_SR, 5'd4, OPC_OP));
        pending_q.push_back(enc_r(F7_ALT, 5'd2, 5'd3, F3_OR, 5'd4, OPC_OP));
        pending_q.push_back(enc_r(F7_ALT, 5'd31, 5'd30, F3_ADD, 5'd29, OPC_OP));
        pending_q.push_back(enc_r(F7_MULDIV, 5'd5, 5'd6, F3_ADD, 5'd7, OPC_OP));
        pending_q.push_back(enc_r(F7_MULDIV, 5'd5, 5'd6, F3_XOR, 5'd7, OPC_OP));
        pending_q.push_back(enc_r(F7_FADD, 5'd1, 5'd2, RM_RTZ, 5'd3, OPC_FOP));
        pending_q.push_back(enc_r(F7_FCVTSW, 5'd5, 5'd2, RM_DYN, 5'd3, OPC_FOP));
        pending_q.push_back(enc_r(F7_FCVTSW, 5'd5, 5'd2, RM_RNE, 5'd3, OPC_FOP));
        pending_q.push_back(enc_r(F7_FSQRT, 5'd0, 5'd31, RM_RNE, 5'd31, OPC_FOP));
        pending_q.push_back(enc_r(F7_FCMP, 5'd8, 5'd9, F3_FEQ, 5'd10, OPC_FOP));
        pending_q.push_back(enc_r(F7_FCMP, 5'd8, 5'd9, F3_FLE, 5'd10, OPC_FOP));
        pending_q.push_back(enc_r(F7_FCMP, 5'd8, 5'd9, F3_RSVD, 5'd10, OPC_FOP));
        pending_q.push_back(enc_r(F7_FSGNJ, 5'd8, 5'd9, F3_FSGNJX, 5'd10, OPC_FOP));
        pending_q.push_back(enc_r(F7_FMVXS, 5'd0, 5'd9, F3_FMV, 5'd10, OPC_FOP));
        pending_q.push_back(enc_r(7'h55, 5'd0, 5'd6, F3_ROT, 5'd7, OPC_ROT));
        pending_q.push_back(enc_r(7'h55, 5'd1, 5'd6, F3_ROT, 5'd7, OPC_ROT));
        pending_q.push_back(enc_r(7'h00, 5'd0, 5'd0, F3_IN, 5'd31, OPC_IO));
        pending_q.push_back(enc_r(7'h00, 5'd0, 5'd1, F3_IN, 5'd31, OPC_IO));
        pending_q.push_back(enc_r(7'h00, 5'd0, 5'd31, F3_OUT, 5'd0, OPC_IO));
        pending_q.push_back(enc_r(7'h00, 5'd0, 5'd31, F3_OUT, 5'd1, OPC_IO));
        pending_q.push_back(enc_r(7'h00, 5'd0, 5'd0, F3_RSVD, 5'd0, OPC_IO));

        // Mostly words with a supported opcode and plausible funct fields; the rest raw.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            w = $urandom;
            if ($urandom_range(0, 9) >= 2)
            begin
                case ($urandom_range(0, 15))
                    0:       w[6:0] = OPC_LUI;
                    1:       w[6:0] = OPC_AUIPC;
                    2:       w[6:0] = OPC_JAL;
                    3:       w[6:0] = OPC_JALR;
                    4:       w[6:0] = OPC_BRANCH;
                    5:       w[6:0] = OPC_LOAD;
                    6:       w[6:0] = OPC_STORE;
                    7, 8:    w[6:0] = OPC_OPIMM;
                    9, 10:   w[6:0] = OPC_OP;
                    11:      w[6:0] = OPC_FLOAD;
                    12:      w[6:0] = OPC_FSTORE;
                    13:      w[6:0] = OPC_ROT;
                    14:      w[6:0] = OPC_IO;
                    default: w[6:0] = OPC_FOP;
                endcase
                case (w[6:0])
                    OPC_OPIMM:
                        if ($urandom_range(0, 3) != 0)
                            w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
                    OPC_OP:
                        case ($urandom_range(0, 3))
                            0:       w[31:25] = F7_BASE;
                            1:       w[31:25] = F7_ALT;
                            2:       w[31:25] = F7_MULDIV;
                            default: ;
                        endcase
                    OPC_FLOAD, OPC_FSTORE:
                        if ($urandom_range(0, 3) != 0)
                            w[14:12] = F3_W;
                    OPC_FOP:
                    begin
                        case ($urandom_range(0, 11))
                            0:       w[31:25] = F7_FADD;
                            1:       w[31:25] = F7_FSUB;
                            2:       w[31:25] = F7_FMUL;
                            3:       w[31:25] = F7_FDIV;
                            4:       w[31:25] = F7_FCMP;
                            5:       w[31:25] = F7_FMVSX;
                            6:       w[31:25] = F7_FMVXS;
                            7:       w[31:25] = F7_FCVTSW;
                            8:       w[31:25] = F7_FCVTWS;
                            9:       w[31:25] = F7_FSQRT;
                            10:      w[31:25] = F7_FSGNJ;
                            default: ;
                        endcase
                        case ($urandom_range(0, 3))
                            0:       w[14:12] = RM_RNE;
                            1:       w[14:12] = F3_FLT;
                            2:       w[14:12] = F3_FEQ;
                            default: ;
                        endcase
                        if ($urandom_range(0, 1))
                            w[24:20] = '0;
                    end
                    OPC_ROT:
                    begin
                        if ($urandom_range(0, 3) != 0)
                            w[14:12] = F3_ROT;
                        if ($urandom_range(0, 1))
                            w[24:20] = '0;
                    end
                    OPC_IO:
                    begin
                        if ($urandom_range(0, 4) != 0)
                            w[14:12] = $urandom_range(0, 1) ? F3_IN : F3_OUT;
                        if ($urandom_range(0, 4) != 0)
                        begin
                            if (w[14:12] == F3_IN)
                            begin
                                w[31:15] = '0;
                            end
                            else
                            begin
                                w[31:20] = '0;
                                w[11:7] = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            pending_q.push_back(w);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d instruction words: %0d valid, %0d unknown, %0d bad rounding mode.",
                 checked, ok_cnt, unknown_cnt, rm_cnt);
        $display("Distinct operations decoded: %0d of %0d; mismatches: %0d.",
                 $countones(op_seen), int'(OP_OUT) + 1, mismatches);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
